// ===== hdl/dasa_pkg.sv =====
`timescale 1ns / 1ps

package dasa_pkg;

  localparam int MAX_ARCS_DEF = 64;
  localparam int HEAD_IN_W    = 7;
  localparam int HEAD_W       = 8;
  localparam int DEP_W        = 6;
  localparam int SIB_W        = 7;

  typedef struct packed {
    logic                     valid;
    logic signed [HEAD_W-1:0] head;
    logic [DEP_W-1:0]         dep;
  } arc_t;

  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cell_ctl_t;

  function automatic logic arc_less(arc_t a, arc_t b);
    logic signed [HEAD_W-1:0] da;
    logic signed [HEAD_W-1:0] db;
    da = $signed({{(HEAD_W-DEP_W){1'b0}}, a.dep});
    db = $signed({{(HEAD_W-DEP_W){1'b0}}, b.dep});
    if (a.head != b.head) begin
      return a.head < b.head;
    end
    return da < db;
  endfunction

endpackage

// ===== hdl/dasa_cell.sv =====
`timescale 1ns / 1ps

module dasa_cell (
  input  logic                clk,
  input  logic                rst,
  input  dasa_pkg::cell_ctl_t ctl,
  input  dasa_pkg::arc_t      new_arc,
  input  dasa_pkg::arc_t      left_arc,
  input  logic                left_less,
  input  dasa_pkg::arc_t      right_arc,
  output dasa_pkg::arc_t      arc,
  output logic                less
);
  import dasa_pkg::*;

  // new arc sorts ahead of this cell's entry (empty cells act as +inf)
  assign less = !arc.valid || arc_less(new_arc, arc);

  always_ff @(posedge clk) begin
    if (rst) begin
      arc.valid <= 1'b0;
    end else if (ctl.clear) begin
      arc.valid <= 1'b0;
    end else if (ctl.insert) begin
      if (left_less) begin
        arc <= left_arc;
      end else if (less) begin
        arc <= new_arc;
      end
    end else if (ctl.shift) begin
      arc <= right_arc;
    end
  end

endmodule

// ===== hdl/dependency_arcs_to_sibling_arcs.sv =====
`timescale 1ns / 1ps

// Collects one dependency tree's arcs, one transaction per cycle when not
// stalled, into a sorted insertion chain of MAX_ARCS cells (each arc lands in
// order as it arrives). The first root arc is held aside and, after the last
// arc, inserted with its head set to the arc count. Triples then leave the
// chain head one per cycle while the output is not stalled. A tree with more
// than MAX_ARCS arcs yields a single transaction with overflow set after its
// last arc. Input is stalled outside the load state: during the root insert,
// while emitting and while sending the overflow transaction.
module dependency_arcs_to_sibling_arcs #(
  parameter int MAX_ARCS = dasa_pkg::MAX_ARCS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [dasa_pkg::HEAD_IN_W-1:0]  arc_head,
  input  logic        [dasa_pkg::DEP_W-1:0]      arc_dep,
  input  logic                                   arc_last,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [dasa_pkg::HEAD_W-1:0]     out_head,
  output logic signed [dasa_pkg::SIB_W-1:0]      out_sibling,
  output logic        [dasa_pkg::DEP_W-1:0]      out_dep,
  output logic                                   out_last,
  output logic                                   overflow
);
  import dasa_pkg::*;

  localparam int CNT_W = $clog2(MAX_ARCS + 1);

  typedef enum logic [1:0] {S_LOAD, S_ROOT, S_EMIT, S_OVF} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic             root_seen;
  logic [DEP_W-1:0] root_dep;
  logic             ovf;
  arc_t             prev;
  logic             prev_valid;

  arc_t      chain [MAX_ARCS];
  logic      less  [MAX_ARCS];
  arc_t      new_arc;
  cell_ctl_t ctl;

  logic accept;
  logic room;
  logic root_now;
  logic slot_free;
  logic load_out;
  logic signed [SIB_W-1:0] sib;

  assign in_stall  = (state != S_LOAD);
  assign accept    = in_valid && !in_stall;
  assign room      = (count != CNT_W'(MAX_ARCS));
  assign root_now  = (arc_head == HEAD_IN_W'(-1)) && !root_seen;
  assign slot_free = !out_valid || !out_stall;
  assign load_out  = slot_free && ((state == S_EMIT) || (state == S_OVF));

  always_comb begin
    new_arc.valid = 1'b1;
    if (state == S_ROOT) begin
      new_arc.head = $signed({{(HEAD_W-CNT_W){1'b0}}, count});
      new_arc.dep  = root_dep;
    end else begin
      new_arc.head = {arc_head[HEAD_IN_W-1], arc_head};
      new_arc.dep  = arc_dep;
    end
    ctl.insert = (state == S_ROOT) || (accept && room && !root_now);
    ctl.shift  = (state == S_EMIT) && slot_free;
    ctl.clear  = (state == S_OVF) && slot_free;
  end

  for (genvar i = 0; i < MAX_ARCS; i++) begin : g_cell
    arc_t left_a;
    logic left_l;
    arc_t right_a;
    if (i == 0) begin : g_first
      assign left_a = '0;
      assign left_l = 1'b0;
    end else begin : g_mid
      assign left_a = chain[i-1];
      assign left_l = less[i-1];
    end
    if (i == MAX_ARCS - 1) begin : g_end
      assign right_a = '0;
    end else begin : g_inner
      assign right_a = chain[i+1];
    end
    dasa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .new_arc   (new_arc),
      .left_arc  (left_a),
      .left_less (left_l),
      .right_arc (right_a),
      .arc       (chain[i]),
      .less      (less[i])
    );
  end

  // sibling of the arc at the chain head
  always_comb begin
    logic signed [HEAD_W-1:0] h;
    logic signed [HEAD_W-1:0] d0;
    logic signed [HEAD_W-1:0] dn;
    logic signed [HEAD_W-1:0] dp;
    h   = chain[0].head;
    d0  = $signed({{(HEAD_W-DEP_W){1'b0}}, chain[0].dep});
    dn  = $signed({{(HEAD_W-DEP_W){1'b0}}, chain[1].dep});
    dp  = $signed({{(HEAD_W-DEP_W){1'b0}}, prev.dep});
    sib = SIB_W'(-1);
    if (h > d0) begin
      if (chain[1].valid && chain[1].head == h && !(h < dn)) begin
        sib = $signed({1'b0, chain[1].dep});
      end
    end else begin
      if (prev_valid && prev.head == h && !(h > dp)) begin
        sib = $signed({1'b0, prev.dep});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      count      <= '0;
      root_seen  <= 1'b0;
      ovf        <= 1'b0;
      prev_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= load_out || (out_valid && out_stall);
      case (state)
        S_LOAD: begin
          prev_valid <= 1'b0;
          if (accept) begin
            if (room) begin
              count <= count + 1'b1;
              if (root_now) begin
                root_seen <= 1'b1;
                root_dep  <= arc_dep;
              end
            end else begin
              ovf <= 1'b1;
            end
            if (arc_last) begin
              if (ovf || !room) begin
                state <= S_OVF;
              end else if (root_seen || root_now) begin
                state <= S_ROOT;
              end else begin
                state <= S_EMIT;
              end
            end
          end
        end
        S_ROOT: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_head    <= chain[0].head;
            out_sibling <= sib;
            out_dep     <= chain[0].dep;
            out_last    <= !chain[1].valid;
            overflow    <= 1'b0;
            prev        <= chain[0];
            prev_valid  <= 1'b1;
            if (!chain[1].valid) begin
              state     <= S_LOAD;
              count     <= '0;
              root_seen <= 1'b0;
              ovf       <= 1'b0;
            end
          end
        end
        S_OVF: begin
          if (slot_free) begin
            out_head    <= '0;
            out_sibling <= '0;
            out_dep     <= '0;
            out_last    <= 1'b1;
            overflow    <= 1'b1;
            state       <= S_LOAD;
            count       <= '0;
            root_seen   <= 1'b0;
            ovf         <= 1'b0;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule
